### src/pdd_pkg.sv
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared types and codes for the positional deque with listing dump.
// ----------------------------------------------------------------------------
package pdd_pkg;

  // operation codes carried on func
  localparam logic [1:0] FUNC_FRONT  = 2'd0;
  localparam logic [1:0] FUNC_BACK   = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  // listing direction codes
  localparam logic DIR_FWD = 1'b0;
  localparam logic DIR_REV = 1'b1;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SHIFT_RD = 7'b0000010,
    ST_SHIFT_WR = 7'b0000100,
    ST_INS_HEAD = 7'b0001000,
    ST_DUMP_RD  = 7'b0010000,
    ST_DUMP_LD  = 7'b0100000,
    ST_DUMP_OUT = 7'b1000000
  } pdd_state_t;

endpackage

### src/positional_deque_with_dump.sv
// ----------------------------------------------------------------------------
// positional_deque_with_dump
// Ordered list of signed 32-bit values with front/back insert, positional
// delete and a full front-to-back then back-to-front listing after each op.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, func, operand) takes one operation per
//   transaction. in_ready is high only while the sequencer is idle.
//   Output channel (out_valid/out_ready) returns 2*n listing items for a list
//   of n entries, or two empty markers when the list is empty; last flags the
//   final item of the operation.
//   The entries live in a RAM with one read port and one write port, walked
//   by ptr during moves and by rstep during the listing. A front insert into
//   a non-full list moves every entry up one slot, through ST_SHIFT_RD and
//   ST_SHIFT_WR for each entry, then writes the head; a delete moves the
//   entries above the position down one slot the same way; a back insert
//   moves nothing. The listing then passes through ST_DUMP_RD and ST_DUMP_LD
//   and delivers one item per cycle while out_ready is high.
//   Reset (rst, synchronous) empties the list; RAM contents are not cleared.
//   A receiver stall holds the current item on the output and freezes the
//   walk; no input is taken until the last item is delivered.
// ----------------------------------------------------------------------------
module positional_deque_with_dump #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [31:0] operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               direction,
  output logic signed [31:0] item_value,
  output logic               list_empty,
  output logic               insert_dropped,
  output logic               last
);
  import pdd_pkg::*;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int STEP_W = $clog2(2 * CAPACITY + 1);
  localparam int SW1    = STEP_W + 1;

  // entry storage and registered read data
  logic [31:0]       mem [CAPACITY];
  logic [31:0]       rdata;
  logic [IDX_W-1:0]  rd_sel;
  logic              we;
  logic [IDX_W-1:0]  wa;
  logic [31:0]       wd;

  // control and operation registers
  pdd_state_t        state;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  ptr;
  logic [31:0]       op_val;
  logic              op_front;
  logic              dropped;
  logic [STEP_W-1:0] rstep;

  // listing helpers
  logic              in_acc;
  logic              out_acc;
  logic [STEP_W-1:0] load_step;
  logic [STEP_W-1:0] tot_m1;
  logic              is_full;
  logic              del_ok;

  // map a listing step to a list position
  function automatic logic [IDX_W-1:0] step_addr(input logic [STEP_W-1:0] k,
                                                 input logic [CNT_W-1:0]  n);
    logic [SW1-1:0] kk;
    logic [SW1-1:0] nn;
    logic [SW1-1:0] a;
    kk = SW1'(k);
    nn = SW1'(n);
    if (kk < nn) begin
      a = kk;
    end else if (kk < (nn << 1)) begin
      a = (nn << 1) - kk - SW1'(1);
    end else begin
      a = '0;
    end
    return a[IDX_W-1:0];
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign del_ok   = !operand[31] && ($unsigned(operand) < 32'(count));

  // step of the item being loaded into the output register
  assign load_step = (state == ST_DUMP_LD) ? '0 : rstep;
  assign tot_m1    = (count == '0) ? STEP_W'(1) : (STEP_W'(count) << 1) - STEP_W'(1);

  // read address select
  always_comb begin
    rd_sel = step_addr(rstep, count);
    unique case (state)
      ST_SHIFT_RD: begin
        rd_sel = op_front ? ptr - IDX_W'(1) : ptr + IDX_W'(1);
      end
      ST_DUMP_RD: begin
        rd_sel = '0;
      end
      ST_DUMP_LD: begin
        rd_sel = step_addr(STEP_W'(1), count);
      end
      ST_DUMP_OUT: begin
        if (out_acc && !last) rd_sel = step_addr(rstep + STEP_W'(1), count);
      end
      default: begin
        rd_sel = step_addr(rstep, count);
      end
    endcase
  end

  // write port select
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = rdata;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && func == FUNC_BACK && !is_full) begin
          we = 1'b1;
          wa = count[IDX_W-1:0];
          wd = operand;
        end
      end
      ST_SHIFT_WR: begin
        we = 1'b1;
        wa = ptr;
        wd = rdata;
      end
      ST_INS_HEAD: begin
        we = 1'b1;
        wa = '0;
        wd = op_val;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // ram with one read port and one write port
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[rd_sel];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            op_val  <= operand;
            dropped <= (func == FUNC_FRONT || func == FUNC_BACK) && is_full;
            case (func)
              FUNC_FRONT: begin
                if (is_full) begin
                  state <= ST_DUMP_RD;
                end else if (count == '0) begin
                  state <= ST_INS_HEAD;
                end else begin
                  ptr      <= count[IDX_W-1:0];
                  op_front <= 1'b1;
                  state    <= ST_SHIFT_RD;
                end
              end
              FUNC_BACK: begin
                if (!is_full) begin
                  count <= count + CNT_W'(1);
                end
                state <= ST_DUMP_RD;
              end
              FUNC_DELETE: begin
                if (del_ok && $unsigned(operand) != 32'(count) - 32'd1) begin
                  ptr      <= operand[IDX_W-1:0];
                  op_front <= 1'b0;
                  state    <= ST_SHIFT_RD;
                end else begin
                  if (del_ok) begin
                    count <= count - CNT_W'(1);
                  end
                  state <= ST_DUMP_RD;
                end
              end
              default: begin
                state <= ST_DUMP_RD;
              end
            endcase
          end
        end
        ST_SHIFT_RD: begin
          state <= ST_SHIFT_WR;
        end
        ST_SHIFT_WR: begin
          if (op_front) begin
            if (ptr == IDX_W'(1)) begin
              state <= ST_INS_HEAD;
            end else begin
              ptr   <= ptr - IDX_W'(1);
              state <= ST_SHIFT_RD;
            end
          end else begin
            if (CNT_W'(ptr) + CNT_W'(2) == count) begin
              count <= count - CNT_W'(1);
              state <= ST_DUMP_RD;
            end else begin
              ptr   <= ptr + IDX_W'(1);
              state <= ST_SHIFT_RD;
            end
          end
        end
        ST_INS_HEAD: begin
          count <= count + CNT_W'(1);
          state <= ST_DUMP_RD;
        end
        ST_DUMP_RD: begin
          state <= ST_DUMP_LD;
        end
        ST_DUMP_LD: begin
          out_valid <= 1'b1;
          rstep     <= STEP_W'(1);
          state     <= ST_DUMP_OUT;
        end
        ST_DUMP_OUT: begin
          if (out_acc) begin
            if (last) begin
              out_valid <= 1'b0;
              state     <= ST_IDLE;
            end else begin
              rstep <= rstep + STEP_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register load
  always_ff @(posedge clk) begin
    if (state == ST_DUMP_LD || (state == ST_DUMP_OUT && out_acc && !last)) begin
      insert_dropped <= dropped;
      last           <= (load_step == tot_m1);
      if (count == '0) begin
        direction  <= (load_step == STEP_W'(1)) ? DIR_REV : DIR_FWD;
        item_value <= '0;
        list_empty <= 1'b1;
      end else begin
        direction  <= (load_step >= STEP_W'(count)) ? DIR_REV : DIR_FWD;
        item_value <= rdata;
        list_empty <= 1'b0;
      end
    end
  end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for positional_deque_with_dump: a queue-fed driver
// applies front/back inserts, positional deletes and no-ops, a scoreboard
// predicts the full forward and reverse listing after each transaction, and
// a monitor compares every listing item field by field under random input
// and output stalls.
// ----------------------------------------------------------------------------
module tb;
  import pdd_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [1:0] FUNC_NOP = 2'd3;

  // operation waiting to be offered to the block
  typedef struct {
    logic [1:0]         code;
    logic signed [31:0] opnd;
    int unsigned        gap;
    bit                 drain_first;
  } deque_op_t;

  // one predicted listing item
  typedef struct {
    logic               dir;
    logic signed [31:0] val;
    logic               empty;
    logic               dropped;
    logic               fin;
  } listing_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         func = '0;
  logic signed [31:0] operand = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               direction;
  logic signed [31:0] item_value;
  logic               list_empty;
  logic               insert_dropped;
  logic               last;

  // stimulus and scoreboard state
  deque_op_t          op_queue[$];
  listing_item_t      expected_listing[$];
  logic signed [31:0] deque_mem[DEPTH];
  int unsigned        deque_len = 0;
  int unsigned        ops_total = 0;
  int unsigned        ops_accepted = 0;
  int unsigned        fail_count = 0;
  int unsigned        gen_len = 0;
  int unsigned        send_wait = 0;
  int unsigned        send_seg_left = 0;
  bit                 send_burst = 0;
  int unsigned        rcv_wait = 0;
  int unsigned        rcv_gap = 0;
  int unsigned        rcv_seg_left = 0;
  bit                 rcv_burst = 0;
  logic               long_hold = 1'b0;
  logic               ready_next;

  positional_deque_with_dump #(.CAPACITY(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .operand(operand),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .direction(direction),
    .item_value(item_value),
    .list_empty(list_empty),
    .insert_dropped(insert_dropped),
    .last(last)
  );

  // clock
  always #5 clk = ~clk;

  // apply one operation to the shadow list and queue the listing it produces
  function automatic void apply_deque_op(logic [1:0] code, logic signed [31:0] opnd);
    logic          dropped;
    int            i;
    listing_item_t li;
    dropped = 1'b0;
    if (code == FUNC_FRONT || code == FUNC_BACK) begin
      if (deque_len >= DEPTH) begin
        dropped = 1'b1;
      end else if (code == FUNC_FRONT) begin
        for (i = deque_len; i > 0; i--) deque_mem[i] = deque_mem[i-1];
        deque_mem[0] = opnd;
        deque_len++;
      end else begin
        deque_mem[deque_len] = opnd;
        deque_len++;
      end
    end else if (code == FUNC_DELETE) begin
      // negative or out-of-range positions leave the list alone
      if (!opnd[31] && $unsigned(opnd) < deque_len) begin
        for (i = int'(opnd); i + 1 < deque_len; i++) deque_mem[i] = deque_mem[i+1];
        deque_len--;
      end
    end
    li.dropped = dropped;
    li.fin = 1'b0;
    if (deque_len == 0) begin
      li.val = '0;
      li.empty = 1'b1;
      li.dir = DIR_FWD;
      expected_listing.push_back(li);
      li.dir = DIR_REV;
      expected_listing.push_back(li);
    end else begin
      li.empty = 1'b0;
      li.dir = DIR_FWD;
      for (i = 0; i < deque_len; i++) begin
        li.val = deque_mem[i];
        expected_listing.push_back(li);
      end
      li.dir = DIR_REV;
      for (i = deque_len; i > 0; i--) begin
        li.val = deque_mem[i-1];
        expected_listing.push_back(li);
      end
    end
    expected_listing[$].fin = 1'b1;
  endfunction

  // queue an operation with a sender gap, tracking the list length it implies
  task automatic add_op(logic [1:0] code, logic signed [31:0] opnd, bit drain);
    deque_op_t op;
    if (send_seg_left == 0) begin
      send_burst = ($urandom_range(0, 3) == 0);
      send_seg_left = $urandom_range(5, 20);
    end
    send_seg_left--;
    op.code = code;
    op.opnd = opnd;
    op.gap = send_burst ? 0 : $urandom_range(0, 11);
    op.drain_first = drain;
    op_queue.push_back(op);
    ops_total++;
    if ((code == FUNC_FRONT || code == FUNC_BACK) && gen_len < DEPTH) gen_len++;
    else if (code == FUNC_DELETE && !opnd[31] && $unsigned(opnd) < gen_len) gen_len--;
  endtask

  // insert value with extremes mixed in
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // driver: offers queued operations, predicts on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_deque_op(func, operand);
        ops_accepted++;
        send_wait = 0;
      end
      if (in_valid && !in_ready) begin
        // hold the offered transaction
      end else if (op_queue.size() != 0 && send_wait >= op_queue[0].gap &&
                   (!op_queue[0].drain_first || expected_listing.size() == 0)) begin
        in_valid <= 1'b1;
        func <= op_queue[0].code;
        operand <= op_queue[0].opnd;
        void'(op_queue.pop_front());
      end else begin
        in_valid <= 1'b0;
        send_wait++;
      end
    end
  end

  // monitor: random output stalls and comparison against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rcv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_listing.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected listing item: dir=%0d val=%0d empty=%0d drop=%0d last=%0d",
                     direction, item_value, list_empty, insert_dropped, last);
        end else begin
          if (direction !== expected_listing[0].dir ||
              item_value !== expected_listing[0].val ||
              list_empty !== expected_listing[0].empty ||
              insert_dropped !== expected_listing[0].dropped ||
              last !== expected_listing[0].fin) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp dir=%0d val=%0d empty=%0d drop=%0d last=%0d, %s",
                       expected_listing[0].dir, expected_listing[0].val,
                       expected_listing[0].empty, expected_listing[0].dropped,
                       expected_listing[0].fin,
                       $sformatf("got dir=%0d val=%0d empty=%0d drop=%0d last=%0d",
                                 direction, item_value, list_empty, insert_dropped, last));
          end
          void'(expected_listing.pop_front());
        end
        if (rcv_seg_left == 0) begin
          rcv_burst = ($urandom_range(0, 3) == 0);
          rcv_seg_left = $urandom_range(10, 40);
        end
        rcv_seg_left--;
        rcv_gap = rcv_burst ? 0 : $urandom_range(0, 11);
        rcv_wait = 0;
      end
      ready_next = !long_hold && (rcv_wait >= rcv_gap);
      if (!ready_next) rcv_wait++;
      out_ready <= ready_next;
    end
  end

  // long receiver hold-off so the block stalls its input
  initial begin
    wait (ops_accepted >= 70);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk);
    long_hold <= 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("** positional_deque_with_dump: FAILED **");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int  n;
    int  r;
    bit  fill_mode;
    logic signed [31:0] pos;

    // empty list: ignored delete and no-op
    add_op(FUNC_DELETE, 32'sd0, 0);
    add_op(FUNC_NOP, $urandom, 0);
    // extremes at both ends
    add_op(FUNC_FRONT, 32'sh7fffffff, 0);
    add_op(FUNC_BACK, 32'sh80000000, 0);
    add_op(FUNC_FRONT, -32'sd1, 0);
    add_op(FUNC_BACK, 32'sd0, 0);
    // negative and out-of-range delete positions
    add_op(FUNC_DELETE, -32'sd1, 0);
    add_op(FUNC_DELETE, 32'sd4, 0);
    add_op(FUNC_DELETE, 32'sh7fffffff, 0);
    add_op(FUNC_NOP, 32'sd1, 0);
    // delete from the middle
    add_op(FUNC_DELETE, 32'sd1, 0);
    // fill up, then inserts into a full list
    for (n = 0; n < 13; n++) add_op(n[0] ? FUNC_BACK : FUNC_FRONT, $urandom, 0);
    add_op(FUNC_FRONT, 32'sh5a5a5a5a, 0);
    add_op(FUNC_BACK, 32'sha5a5a5a5, 0);
    // delete at the back end, then at the front
    add_op(FUNC_DELETE, 32'sd15, 0);
    add_op(FUNC_DELETE, 32'sd0, 0);

    // random part: fill and drain phases with random content
    fill_mode = 1;
    for (n = 0; n < 132; n++) begin
      if (gen_len == 0) fill_mode = 1;
      else if (gen_len == DEPTH && $urandom_range(0, 2) == 0) fill_mode = 0;
      else if ($urandom_range(0, 29) == 0) fill_mode = !fill_mode;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        add_op(FUNC_NOP, $urandom, n == 40 || n == 100);
      end else if (fill_mode ? r < 75 : r < 30) begin
        add_op($urandom_range(0, 1) ? FUNC_BACK : FUNC_FRONT, pick_value(),
               n == 40 || n == 100);
      end else begin
        r = $urandom_range(0, 9);
        if (r < 7) pos = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
        else if (r < 9) pos = gen_len + $urandom_range(0, 3);
        else pos = $urandom;
        add_op(FUNC_DELETE, pos, n == 40 || n == 100);
      end
    end

    // reset
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // wait for every transaction and its listing, then let the block settle
    while (ops_accepted < ops_total || expected_listing.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("** positional_deque_with_dump: PASSED **");
    end else begin
      $display("** positional_deque_with_dump: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
src/pdd_pkg.sv
src/positional_deque_with_dump.sv
sim/tb.sv
